// ===== rtl/aalr_pkg.sv =====
package aalr_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int SLOPE_FRAC_BITS = 16;

   localparam int IN_W    = 21;
   localparam int PIX_W   = 14;
   localparam int COV_W   = 8;
   localparam int CFG_W   = 13;
   localparam int SLOPE_W = SLOPE_FRAC_BITS + 2;
   localparam int ICPT_W  = SLOPE_FRAC_BITS + PIX_W;
   localparam int GAP_W   = COORD_FRAC_BITS + 1;
   localparam int WFRAC_W = SLOPE_FRAC_BITS + 1;
   localparam int WEND_W  = SLOPE_FRAC_BITS + COORD_FRAC_BITS + 1;
   localparam int PROD_W  = SLOPE_W + GAP_W;
   localparam int RND_W   = PROD_W - COORD_FRAC_BITS;
   localparam int RSUM_W  = SLOPE_FRAC_BITS + COORD_FRAC_BITS + COV_W + 1;

   localparam int QUO_W     = SLOPE_FRAC_BITS + 1;
   localparam int REM_W     = IN_W;
   localparam int DVD_W     = IN_W + QUO_W;
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);

   localparam int MUL_AW = SLOPE_FRAC_BITS + COORD_FRAC_BITS + 2;
   localparam int MUL_BW = COORD_FRAC_BITS + 2;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0]   IMAGE_SIZE_RESET = CFG_W'(1024);
   localparam logic [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1) << SLOPE_FRAC_BITS;
   localparam logic [WFRAC_W-1:0] WFRAC_ONE = WFRAC_W'(1) << SLOPE_FRAC_BITS;
   localparam logic [GAP_W-1:0]   GAP_ONE   = GAP_W'(1) << COORD_FRAC_BITS;
   localparam logic [MUL_BW-1:0]  COV_FULL  = MUL_BW'(255);

endpackage

// ===== rtl/aalr_if.sv =====
interface aalr_req_if;
   import aalr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    action;
   logic signed [IN_W-1:0]  start_x;
   logic signed [IN_W-1:0]  start_y;
   logic signed [IN_W-1:0]  end_x;
   logic signed [IN_W-1:0]  end_y;

   modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);

endinterface

interface aalr_rsp_if;
   import aalr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   logic [COV_W-1:0]        coverage;
   logic                    in_image;
   logic                    line_done;

   modport source (output valid, pixel_x, pixel_y, coverage, in_image, line_done, input ready);
   modport sink (input valid, pixel_x, pixel_y, coverage, in_image, line_done, output ready);

endinterface

// ===== rtl/aalr_div.sv =====
module aalr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aalr_pkg::DVD_W-1:0]    dividend,
   input  logic [aalr_pkg::REM_W-1:0]    divisor,
   output logic                          done,
   output logic [aalr_pkg::QUO_W-1:0]    quotient
);
   import aalr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     acc_ff, acc_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [REM_W:0]       trial;
   logic [REM_W:0]       diff;

   assign trial = {rem_ff, acc_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      if (start) begin
         rem_in   = dividend[DVD_W-1:QUO_W];
         acc_in   = dividend[QUO_W-1:0];
         count_in = DIV_CNT_W'(QUO_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[REM_W]) begin
            rem_in = diff[REM_W-1:0];
            acc_in = {acc_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[REM_W-1:0];
            acc_in = {acc_ff[QUO_W-2:0], 1'b0};
         end
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

endmodule

// ===== rtl/aalr_mul.sv =====
module aalr_mul (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [aalr_pkg::MUL_AW-1:0] op_a,
   input  logic signed [aalr_pkg::MUL_BW-1:0] op_b,
   output logic signed [aalr_pkg::MUL_PW-1:0] product
);
   import aalr_pkg::*;

   logic signed [MUL_PW-1:0] product_ff, product_in;

   always_comb begin
      product_in = product_ff;
      if (enable) begin
         product_in = MUL_PW'(op_a) * MUL_PW'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/antialiased_line_rasterizer_unit.sv =====
// Anti-aliased line rasterizer, Wu style, fixed point.
// req_chan (valid/ready) takes transactions: action 0 starts a line from two
// Q12.8 endpoints, action 1 advances one interior column of the active line.
// rsp_chan (valid/ready) returns pixels with coverage, an in-image flag and
// a flag on the final pixel of the line. csr_* is an APB port holding image
// width (0x0) and image height (0x4); pready is tied high.
// A start runs the accepting cycle, 5 set-up steps, a shift-subtract divide
// for the gradient (17 steps, then its done flag), then per endpoint four
// steps for column and intercept and three steps per pixel through the one
// shared multiplier. It gives four pixels. A line with no extent along its
// major axis skips the divide. An advance gives two pixels, each pixel
// going once through the shared multiplier for its coverage. An advance
// with no active line is taken and gives nothing.
// req_chan.ready is high only while the sequencer is idle. One output
// register holds the latest pixel; while rsp_chan stalls, the sequencer
// waits on it, and a new transaction may still be taken while it is full.
// Reset clears the active line, empties the output register and sets both
// image sizes to 1024.
module antialiased_line_rasterizer_unit (
   input  logic                          clock,
   input  logic                          reset,
   aalr_req_if.sink                      req_chan,
   aalr_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [aalr_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [aalr_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [aalr_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import aalr_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ABS    = 4'd1;
   localparam logic [3:0] ST_SWAP   = 4'd2;
   localparam logic [3:0] ST_ORDER  = 4'd3;
   localparam logic [3:0] ST_DIFF   = 4'd4;
   localparam logic [3:0] ST_DSTART = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_COL    = 4'd7;
   localparam logic [3:0] ST_DXC    = 4'd8;
   localparam logic [3:0] ST_RND    = 4'd9;
   localparam logic [3:0] ST_YEND   = 4'd10;
   localparam logic [3:0] ST_PW     = 4'd11;
   localparam logic [3:0] ST_PS     = 4'd12;
   localparam logic [3:0] ST_POUT   = 4'd13;

   localparam int F = COORD_FRAC_BITS;
   localparam int S = SLOPE_FRAC_BITS;

   localparam logic [IN_W:0]     COL_HALF    = (IN_W + 1)'(1) << (F - 1);
   localparam logic [IN_W:0]     COL_HALF_LO = COL_HALF - (IN_W + 1)'(1);
   localparam logic [PROD_W-1:0] RND_HALF    = PROD_W'(1) << (F - 1);
   localparam logic [RSUM_W-1:0] RSUM_INT    = RSUM_W'(1) << (S - 1);
   localparam logic [RSUM_W-1:0] RSUM_END    = RSUM_W'(1) << (S + F - 1);

   logic [3:0]           state_ff, state_in;
   logic [CFG_W-1:0]     width_ff, width_in;
   logic [CFG_W-1:0]     height_ff, height_in;

   logic [IN_W-1:0]      x0_ff, x0_in, y0_ff, y0_in;
   logic [IN_W-1:0]      x1_ff, x1_in, y1_ff, y1_in;
   logic [IN_W-1:0]      span_a_ff, span_a_in;
   logic [IN_W-1:0]      span_b_ff, span_b_in;
   logic                 dyneg_ff, dyneg_in;

   logic                 line_active_ff, line_active_in;
   logic                 steep_ff, steep_in;
   logic [SLOPE_W-1:0]   slope_ff, slope_in;
   logic [ICPT_W-1:0]    intercept_ff, intercept_in;
   logic [PIX_W-1:0]     column_now_ff, column_now_in;
   logic [PIX_W-1:0]     column_last_ff, column_last_in;

   logic                 ep_ff, ep_in;
   logic                 half_ff, half_in;
   logic                 interior_ff, interior_in;
   logic                 none_ff, none_in;
   logic [PIX_W-1:0]     col_ff, col_in;
   logic [GAP_W-1:0]     gap_ff, gap_in;
   logic [RND_W-1:0]     rnd_ff, rnd_in;
   logic [ICPT_W-1:0]    cur_ff, cur_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]     pixel_x_ff, pixel_x_in;
   logic [PIX_W-1:0]     pixel_y_ff, pixel_y_in;
   logic [COV_W-1:0]     coverage_ff, coverage_in;
   logic                 in_image_ff, in_image_in;
   logic                 line_done_ff, line_done_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 csr_write;
   logic [IN_W-1:0]      xe, ye;
   logic [IN_W:0]        dx_p, dx_n, dy_p, dy_n;
   logic [IN_W:0]        col_sum;
   logic [F-1:0]         gap_raw;
   logic [GAP_W-1:0]     dxc;
   logic [S-1:0]         fy;
   logic [WFRAC_W-1:0]   wfrac;
   logic [PROD_W-1:0]    rnd_sum;
   logic [ICPT_W-1:0]    ye_ext;
   logic [ICPT_W-1:0]    slope_ext;
   logic [PIX_W:0]       row;
   logic [PIX_W:0]       colx;
   logic [PIX_W:0]       px, py;
   logic                 in_img;
   logic [RSUM_W-1:0]    rsum;
   logic [COV_W:0]       cov9;
   logic [COV_W-1:0]     cov8;
   logic                 last_col;
   logic                 done_bit;

   logic                 div_start;
   logic [DVD_W-1:0]     div_dividend;
   logic                 div_done;
   logic [QUO_W-1:0]     div_quotient;

   logic                     mul_en;
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_PW-1:0] mul_p;

   aalr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (span_a_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   aalr_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign req_fire  = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   assign xe = ep_ff ? x1_ff : x0_ff;
   assign ye = ep_ff ? y1_ff : y0_ff;

   assign dx_p = {x1_ff[IN_W-1], x1_ff} - {x0_ff[IN_W-1], x0_ff};
   assign dx_n = {x0_ff[IN_W-1], x0_ff} - {x1_ff[IN_W-1], x1_ff};
   assign dy_p = {y1_ff[IN_W-1], y1_ff} - {y0_ff[IN_W-1], y0_ff};
   assign dy_n = {y0_ff[IN_W-1], y0_ff} - {y1_ff[IN_W-1], y1_ff};

   assign col_sum = {xe[IN_W-1], xe} + (xe[IN_W-1] ? COL_HALF_LO : COL_HALF);
   assign gap_raw = {~xe[F-1], xe[F-2:0]};
   assign dxc     = {col_ff[0], {F{1'b0}}} - xe[F:0];

   assign fy    = cur_ff[S-1:0];
   assign wfrac = half_ff ? {1'b0, fy} : WFRAC_ONE - {1'b0, fy};

   assign rnd_sum   = mul_p[PROD_W-1:0] + RND_HALF;
   assign ye_ext    = {{(ICPT_W - IN_W){ye[IN_W-1]}}, ye} << (S - F);
   assign slope_ext = {{(ICPT_W - SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff};

   assign row  = {cur_ff[ICPT_W-1], cur_ff[ICPT_W-1:S]} + {{PIX_W{1'b0}}, half_ff};
   assign colx = {col_ff[PIX_W-1], col_ff};
   assign px   = steep_ff ? row : colx;
   assign py   = steep_ff ? colx : row;

   assign in_img = !px[PIX_W] && (px[PIX_W-1:0] < {1'b0, width_ff}) &&
                   !py[PIX_W] && (py[PIX_W-1:0] < {1'b0, height_ff});

   assign rsum = mul_p[RSUM_W-1:0] + (interior_ff ? RSUM_INT : RSUM_END);
   assign cov9 = interior_ff ? rsum[S+COV_W:S] : rsum[S+F+COV_W:S+F];
   assign cov8 = cov9[COV_W] ? {COV_W{1'b1}} : cov9[COV_W-1:0];

   assign last_col = $signed(column_now_ff) >= $signed(column_last_ff);
   assign done_bit = half_ff && (interior_ff ? last_col : (ep_ff && none_ff));

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      x0_in          = x0_ff;
      y0_in          = y0_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      span_a_in      = span_a_ff;
      span_b_in      = span_b_ff;
      dyneg_in       = dyneg_ff;
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      slope_in       = slope_ff;
      intercept_in   = intercept_ff;
      column_now_in  = column_now_ff;
      column_last_in = column_last_ff;
      ep_in          = ep_ff;
      half_in        = half_ff;
      interior_in    = interior_ff;
      none_in        = none_ff;
      col_in         = col_ff;
      gap_in         = gap_ff;
      rnd_in         = rnd_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      coverage_in    = coverage_ff;
      in_image_in    = in_image_ff;
      line_done_in   = line_done_ff;
      div_start      = 1'b0;
      div_dividend   = DVD_W'({span_b_ff, {S{1'b0}}}) + DVD_W'(span_a_ff >> 1);
      mul_en         = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      if (csr_write) begin
         if (csr_paddr[CSR_AW-1] == CSR_IDX_WIDTH) begin
            width_in = csr_pwdata[CFG_W-1:0];
         end else begin
            height_in = csr_pwdata[CFG_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_chan.action) begin
                  x0_in       = req_chan.start_x;
                  y0_in       = req_chan.start_y;
                  x1_in       = req_chan.end_x;
                  y1_in       = req_chan.end_y;
                  ep_in       = 1'b0;
                  half_in     = 1'b0;
                  interior_in = 1'b0;
                  state_in    = ST_ABS;
               end else if (line_active_ff) begin
                  col_in      = column_now_ff;
                  cur_in      = intercept_ff;
                  half_in     = 1'b0;
                  interior_in = 1'b1;
                  state_in    = ST_PS;
               end
            end
         end
         ST_ABS: begin
            span_a_in = dx_p[IN_W] ? dx_n[IN_W-1:0] : dx_p[IN_W-1:0];
            span_b_in = dy_p[IN_W] ? dy_n[IN_W-1:0] : dy_p[IN_W-1:0];
            state_in  = ST_SWAP;
         end
         ST_SWAP: begin
            steep_in = span_b_ff > span_a_ff;
            if (span_b_ff > span_a_ff) begin
               x0_in = y0_ff;
               y0_in = x0_ff;
               x1_in = y1_ff;
               y1_in = x1_ff;
            end
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            if ($signed(x0_ff) > $signed(x1_ff)) begin
               x0_in = x1_ff;
               y0_in = y1_ff;
               x1_in = x0_ff;
               y1_in = y0_ff;
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            span_a_in = dx_p[IN_W-1:0];
            dyneg_in  = dy_p[IN_W];
            span_b_in = dy_p[IN_W] ? dy_n[IN_W-1:0] : dy_p[IN_W-1:0];
            state_in  = ST_DSTART;
         end
         ST_DSTART: begin
            if (span_a_ff == '0) begin
               slope_in = SLOPE_ONE;
               state_in = ST_COL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in = dyneg_ff ? SLOPE_W'(-{1'b0, div_quotient})
                                   : SLOPE_W'({1'b0, div_quotient});
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            col_in   = col_sum[IN_W:F];
            gap_in   = ep_ff ? {1'b0, gap_raw} : GAP_ONE - {1'b0, gap_raw};
            state_in = ST_DXC;
         end
         ST_DXC: begin
            mul_en = 1'b1;
            mul_a  = {{(MUL_AW - SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff};
            mul_b  = {{(MUL_BW - GAP_W){dxc[GAP_W-1]}}, dxc};
            if (!ep_ff) begin
               column_now_in = col_ff + PIX_W'(1);
            end else begin
               none_in        = !($signed(column_now_ff) < $signed(col_ff));
               column_last_in = col_ff - PIX_W'(1);
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            rnd_in   = rnd_sum[PROD_W-1:F];
            state_in = ST_YEND;
         end
         ST_YEND: begin
            cur_in   = ye_ext + {{(ICPT_W - RND_W){rnd_ff[RND_W-1]}}, rnd_ff};
            state_in = ST_PW;
         end
         ST_PW: begin
            mul_en = 1'b1;
            mul_a  = MUL_AW'(wfrac);
            mul_b  = MUL_BW'(gap_ff);
            if (!ep_ff && !half_ff) begin
               intercept_in = cur_ff + slope_ext;
            end
            state_in = ST_PS;
         end
         ST_PS: begin
            mul_en   = 1'b1;
            mul_a    = interior_ff ? MUL_AW'(wfrac) : MUL_AW'(mul_p[WEND_W-1:0]);
            mul_b    = COV_FULL;
            state_in = ST_POUT;
         end
         ST_POUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pixel_x_in   = px[PIX_W-1:0];
               pixel_y_in   = py[PIX_W-1:0];
               coverage_in  = cov8;
               in_image_in  = in_img;
               line_done_in = done_bit;
               if (!half_ff) begin
                  half_in  = 1'b1;
                  state_in = interior_ff ? ST_PS : ST_PW;
               end else if (interior_ff) begin
                  intercept_in  = intercept_ff + slope_ext;
                  column_now_in = column_now_ff + PIX_W'(1);
                  if (last_col) begin
                     line_active_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end else if (!ep_ff) begin
                  ep_in    = 1'b1;
                  half_in  = 1'b0;
                  state_in = ST_COL;
               end else begin
                  line_active_in = !none_ff;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_ff       <= IMAGE_SIZE_RESET;
         height_ff      <= IMAGE_SIZE_RESET;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ep_ff          <= 1'b0;
         half_ff        <= 1'b0;
         interior_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         ep_ff          <= ep_in;
         half_ff        <= half_in;
         interior_ff    <= interior_in;
      end
      x0_ff          <= x0_in;
      y0_ff          <= y0_in;
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      span_a_ff      <= span_a_in;
      span_b_ff      <= span_b_in;
      dyneg_ff       <= dyneg_in;
      steep_ff       <= steep_in;
      slope_ff       <= slope_in;
      intercept_ff   <= intercept_in;
      column_now_ff  <= column_now_in;
      column_last_ff <= column_last_in;
      none_ff        <= none_in;
      col_ff         <= col_in;
      gap_ff         <= gap_in;
      rnd_ff         <= rnd_in;
      cur_ff         <= cur_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      coverage_ff    <= coverage_in;
      in_image_ff    <= in_image_in;
      line_done_ff   <= line_done_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_x   = pixel_x_ff;
   assign rsp_chan.pixel_y   = pixel_y_ff;
   assign rsp_chan.coverage  = coverage_ff;
   assign rsp_chan.in_image  = in_image_ff;
   assign rsp_chan.line_done = line_done_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == CSR_IDX_HEIGHT) ?
                       CSR_DW'(height_ff) : CSR_DW'(width_ff);

endmodule
